### rtl/assert_macros.svh
// assertion macros shared by the decimal scan rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define DSS_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define DSS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/dss_pkg.sv
// shared constants, types and functions of the decimal seven-segment scan
package dss_pkg;

    localparam int VALUE_W         = 27;
    localparam int SEL_W           = 8;
    localparam int SEG_W           = 8;
    localparam int BCD_W           = 4;
    localparam int HALF_W          = 14;
    localparam int PAIR_W          = 7;
    localparam int DIGITS_FULL     = 8;
    localparam int DIGIT_COUNT_DEF = 8;
    localparam int PIPE_STAGES     = 7;

    // reciprocal constants for division by 10000, 100 and 10
    localparam logic [VALUE_W-1:0] RECIP_10K = 27'd109951163;
    localparam int                 SHIFT_10K = 40;
    localparam logic [HALF_W-1:0]  TEN_K     = 14'd10000;
    localparam logic [12:0]        RECIP_100 = 13'd5243;
    localparam int                 SHIFT_100 = 19;
    localparam logic [PAIR_W-1:0]  HUNDRED   = 7'd100;
    localparam logic [7:0]         RECIP_10  = 8'd205;
    localparam int                 SHIFT_10  = 11;
    localparam logic [BCD_W-1:0]   TEN       = 4'd10;

    localparam logic [SEG_W-1:0] BLANK_SEG = 8'hFF;

    typedef logic [BCD_W-1:0] bcd_t;
    typedef logic [SEG_W-1:0] seg_t;

    // largest value that fits n decimal digits
    function automatic int max_shown(input int n);
        int lim;
        lim = 1;
        for (int k = 0; k < n; k++)
        begin
            lim = lim * 10;
        end
        return lim - 1;
    endfunction

    // active-low segments, decimal point off
    function automatic seg_t seg_of(input bcd_t d);
        seg_t s;
        case (d)
            4'd0:    s = 8'hC0;
            4'd1:    s = 8'hF9;
            4'd2:    s = 8'hA4;
            4'd3:    s = 8'hB0;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h92;
            4'd6:    s = 8'h82;
            4'd7:    s = 8'hF8;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h90;
            default: s = BLANK_SEG;
        endcase
        return s;
    endfunction

endpackage

### rtl/dss_if.sv
// request channels of the decimal scan: number in, digit frames out
interface dss_value_if;
    logic                        valid;
    logic                        ready;
    logic [dss_pkg::VALUE_W-1:0] shown_value;

    modport source (output valid, output shown_value, input ready);
    modport sink (input valid, input shown_value, output ready);
endinterface

interface dss_frame_if;
    logic                      valid;
    logic                      ready;
    logic [dss_pkg::SEL_W-1:0] digit_select;
    logic [dss_pkg::SEG_W-1:0] segment_pattern;
    logic                      last_digit;

    modport source (output valid, output digit_select, output segment_pattern,
                    output last_digit, input ready);
    modport sink (input valid, input digit_select, input segment_pattern,
                  input last_digit, output ready);
endinterface

### rtl/dss_bcd_pipe.sv
// pipelined saturate, binary to decimal conversion and segment encoding
`include "assert_macros.svh"

module dss_bcd_pipe #(
    parameter int DIGIT_COUNT = dss_pkg::DIGIT_COUNT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    dss_value_if.sink             shown,
    output logic                  seg_valid,
    input  logic                  seg_ready,
    output logic [DIGIT_COUNT-1:0][dss_pkg::SEG_W-1:0] seg
);

    localparam int VW = dss_pkg::VALUE_W;
    localparam int HW = dss_pkg::HALF_W;
    localparam int PW = dss_pkg::PAIR_W;
    localparam int BW = dss_pkg::BCD_W;
    localparam int NS = dss_pkg::PIPE_STAGES;
    localparam int ND = dss_pkg::DIGITS_FULL;
    localparam logic [VW-1:0] MAX_SHOWN = VW'(dss_pkg::max_shown(DIGIT_COUNT));

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] en;

    // stage payloads
    logic [VW-1:0] sat_reg;
    logic [VW-1:0] val2_reg;
    logic [HW-1:0] hi2_reg;
    logic [HW-1:0] hi3_reg;
    logic [HW-1:0] lo3_reg;
    logic [HW-1:0] hi4_reg;
    logic [HW-1:0] lo4_reg;
    logic [PW-1:0] hq4_reg;
    logic [PW-1:0] lq4_reg;
    logic [3:0][PW-1:0] pair_reg;
    logic [ND-1:0][BW-1:0] digit_reg;
    logic [DIGIT_COUNT-1:0][dss_pkg::SEG_W-1:0] seg_reg;

    logic [VW-1:0] sat_next;
    logic [2*VW-1:0] prod_10k;
    logic [HW-1:0] hi2_next;
    logic [HW-1:0] lo3_next;
    logic [VW-1:0] prod_hq;
    logic [VW-1:0] prod_lq;
    logic [3:0][PW-1:0] pair_next;
    logic [ND-1:0][BW-1:0] digit_next;
    logic [ND-1:0][dss_pkg::SEG_W-1:0] seg_full;
    logic [DIGIT_COUNT-1:0][dss_pkg::SEG_W-1:0] seg_next;

    // stage i loads when empty or when its content moves on
    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || seg_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next = valid_reg;
        if (en[0])
        begin
            valid_next[0] = shown.valid;
        end
        for (int i = 1; i < NS; i++)
        begin
            if (en[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    assign shown.ready = en[0];
    assign seg_valid   = valid_reg[NS-1];
    assign seg         = seg_reg;

    // stage arithmetic
    always_comb
    begin
        sat_next = (shown.shown_value > MAX_SHOWN) ? MAX_SHOWN : shown.shown_value;
        prod_10k = (2*VW)'(sat_reg) * (2*VW)'(dss_pkg::RECIP_10K);
        hi2_next = prod_10k[dss_pkg::SHIFT_10K +: HW];
        lo3_next = HW'(val2_reg - VW'(hi2_reg) * VW'(dss_pkg::TEN_K));
        prod_hq  = VW'(hi3_reg) * VW'(dss_pkg::RECIP_100);
        prod_lq  = VW'(lo3_reg) * VW'(dss_pkg::RECIP_100);
        pair_next[0] = hq4_reg;
        pair_next[1] = PW'(hi4_reg - HW'(hq4_reg) * HW'(dss_pkg::HUNDRED));
        pair_next[2] = lq4_reg;
        pair_next[3] = PW'(lo4_reg - HW'(lq4_reg) * HW'(dss_pkg::HUNDRED));
    end

    // two decimal digits from each pair below 100
    always_comb
    begin
        logic [14:0] prod_ten;
        logic [BW-1:0] tens;
        for (int p = 0; p < 4; p++)
        begin
            prod_ten = 15'(pair_reg[p]) * 15'(dss_pkg::RECIP_10);
            tens     = prod_ten[dss_pkg::SHIFT_10 +: BW];
            digit_next[2*p]   = tens;
            digit_next[2*p+1] = BW'(pair_reg[p] - PW'(tens) * PW'(dss_pkg::TEN));
        end
    end

    // leading zeros blank, rightmost digit always shown
    always_comb
    begin
        logic seen;
        seen = 1'b0;
        for (int i = 0; i < ND; i++)
        begin
            seen = seen || (digit_reg[i] != '0) || (i == ND - 1);
            seg_full[i] = seen ? dss_pkg::seg_of(digit_reg[i]) : dss_pkg::BLANK_SEG;
        end
    end

    // right-aligned: frame y shows the y-th of the lowest DIGIT_COUNT digits
    for (genvar y = 0; y < DIGIT_COUNT; y++)
    begin : g_frame
        assign seg_next[y] = seg_full[ND-DIGIT_COUNT+y];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sat_reg <= sat_next;
        end
        if (en[1])
        begin
            val2_reg <= sat_reg;
            hi2_reg  <= hi2_next;
        end
        if (en[2])
        begin
            hi3_reg <= hi2_reg;
            lo3_reg <= lo3_next;
        end
        if (en[3])
        begin
            hi4_reg <= hi3_reg;
            lo4_reg <= lo3_reg;
            hq4_reg <= prod_hq[dss_pkg::SHIFT_100 +: PW];
            lq4_reg <= prod_lq[dss_pkg::SHIFT_100 +: PW];
        end
        if (en[4])
        begin
            pair_reg <= pair_next;
        end
        if (en[5])
        begin
            digit_reg <= digit_next;
        end
        if (en[6])
        begin
            seg_reg <= seg_next;
        end
    end

    `DSS_ASSERT_NOW(a_sat_limit, clk, rst_n, valid_reg[0], sat_reg <= MAX_SHOWN,
        "saturated value above limit")
    `DSS_ASSERT_NOW(a_hi_range, clk, rst_n, valid_reg[1], hi2_reg < dss_pkg::TEN_K,
        "upper half out of range")
    `DSS_ASSERT_NOW(a_lo_range, clk, rst_n, valid_reg[2], lo3_reg < dss_pkg::TEN_K,
        "lower half out of range")

endmodule

### rtl/decimal_seven_segment_scan_top.sv
// top level of the decimal seven-segment scan: conversion pipe and frame scan-out
// first frame: the number passes the 7 pipe stages, then loads into the scan-out registers
// the frame output sets the pace: one frame a cycle while frames.ready is high, new number as the final frame leaves
// the seven-stage conversion pipe keeps taking numbers while a scan is still going out, until its stages are full
// reset: asynchronous, clears all valid bits and the scan-busy flag, sets the digit select to the first digit
`include "assert_macros.svh"

module decimal_seven_segment_scan_top #(
    parameter int DIGIT_COUNT = dss_pkg::DIGIT_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    dss_value_if.sink   shown,
    dss_frame_if.source frames
);

    localparam int SW = dss_pkg::SEG_W;

    // pattern set for one number, frame 0 (leftmost) in element 0
    logic                          seg_valid;
    logic                          seg_ready;
    logic [DIGIT_COUNT-1:0][SW-1:0] seg;

    dss_bcd_pipe #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .shown     (shown),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg)
    );

    // scan-out: a pattern shift line and a one-hot digit select that walk together
    logic                           busy_reg;
    logic                           busy_next;
    logic [DIGIT_COUNT-1:0][SW-1:0] pat_reg;
    logic [DIGIT_COUNT-1:0][SW-1:0] pat_next;
    logic [dss_pkg::SEL_W-1:0]      sel_reg;
    logic [dss_pkg::SEL_W-1:0]      sel_next;
    logic                           last;
    logic                           take;
    logic                           load;

    assign last = sel_reg[DIGIT_COUNT-1];
    assign take = busy_reg && frames.ready;

    // next scan may start in the cycle the final frame leaves
    assign seg_ready = !busy_reg || (frames.ready && last);
    assign load      = seg_valid && seg_ready;

    always_comb
    begin
        busy_next = busy_reg;
        pat_next  = pat_reg;
        sel_next  = sel_reg;
        if (load)
        begin
            busy_next = 1'b1;
            pat_next  = seg;
            sel_next  = dss_pkg::SEL_W'(1);
        end
        else if (take)
        begin
            if (last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pat_next = pat_reg >> SW;
                sel_next = sel_reg << 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sel_reg  <= dss_pkg::SEL_W'(1);
        end
        else
        begin
            busy_reg <= busy_next;
            sel_reg  <= sel_next;
        end
    end

    // pattern payload, no reset needed
    always_ff @(posedge clk)
    begin
        pat_reg <= pat_next;
    end

    assign frames.valid           = busy_reg;
    assign frames.digit_select    = sel_reg;
    assign frames.segment_pattern = pat_reg[0];
    assign frames.last_digit      = last;

    // select is one-hot while a scan goes out
    `DSS_ASSERT_NOW(a_sel_onehot, clk, rst_n, busy_reg, $onehot(sel_reg),
        "digit select not one-hot")
    // final frame taken with nothing waiting ends the scan
    `DSS_ASSERT_NEXT(a_scan_end, clk, rst_n, take && last && !seg_valid, !busy_reg,
        "scan did not end after final frame")
    // a frame taken mid-scan moves the select one digit right
    `DSS_ASSERT_NEXT(a_sel_step, clk, rst_n, take && !last,
        busy_reg && (sel_reg == ($past(sel_reg) << 1)),
        "digit select did not advance")

endmodule
